// ----- rtl/reaction_diffusion_stencil_step_defines.svh -----
// ----------------------------------------------------------------------------
// reaction diffusion stencil step - assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef REACTION_DIFFUSION_STENCIL_STEP_DEFINES_SVH
`define REACTION_DIFFUSION_STENCIL_STEP_DEFINES_SVH

// same-cycle implication
`define RDSS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RDSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rdss_pkg.sv -----
// ----------------------------------------------------------------------------
// rdss_pkg
// shared constants, types and fixed-point helpers of the stencil step
// ----------------------------------------------------------------------------
package rdss_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int SOURCE_GENES  = 7;
   localparam int FIRST_TARGET  = 3;
   localparam int GENES_IN      = 7;
   localparam int TARGETS       = 4;
   localparam int DATA_W        = 32;
   localparam int REG_W         = 31;
   localparam int TGT_W         = 2;
   localparam int SRC_W         = $clog2(SOURCE_GENES);
   localparam int GENE_W        = $clog2(GENES_IN);

   localparam int COEF_HALF_BASE = SOURCE_GENES * TARGETS;
   localparam int COEF_DEPTH     = 2 * COEF_HALF_BASE;
   localparam int COEF_AW        = $clog2(COEF_HALF_BASE);
   localparam int COEF_IDX_W     = 6;

   localparam int NUM_W     = DATA_W + FRACTION_BITS;
   localparam int DEN_W     = DATA_W + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W - FRACTION_BITS + 4;

   // request tdata layout
   localparam int POS_FIRST  = GENES_IN * DATA_W;
   localparam int POS_IDX    = POS_FIRST + 1;
   localparam int POS_VAL    = POS_IDX + COEF_IDX_W;
   localparam int REQ_BITS   = POS_VAL + DATA_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = TARGETS * DATA_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 2'd2;
   localparam logic [REG_W-1:0]     STEP_RESET = 31'd65536;

   localparam logic KIND_COEF = 1'b0;
   localparam logic KIND_CELL = 1'b1;

   localparam logic [1:0] FILL_EMPTY = 2'd0;
   localparam logic [1:0] FILL_ONE   = 2'd1;
   localparam logic [1:0] FILL_TWO   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_KD, ST_KDSAT, ST_RD, ST_DEN, ST_DIV, ST_ACC,
      ST_REA, ST_DIF, ST_DEC, ST_SUMT, ST_PUSH, ST_SHIFT
   } state_type;

   typedef struct packed {
      logic                     start;
      logic signed [NUM_W-1:0]  num;
      logic signed [DEN_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic                             eol;
      logic [TARGETS-1:0][DATA_W-1:0]   genes;
   } result_type;

   // saturate to signed 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
      if (x[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){x[DATA_W-1]}})
         return x[DATA_W-1:0];
      else if (x[PROD_W-1])
         return {1'b1, {(DATA_W-1){1'b0}}};
      else
         return {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

   // floor shift by the fraction then saturate
   function automatic logic signed [DATA_W-1:0] asr_sat(input logic signed [PROD_W-1:0] x);
      return sat32(x >>> FRACTION_BITS);
   endfunction

endpackage

// ----- rtl/rdss_ram.sv -----
// ----------------------------------------------------------------------------
// rdss_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rdss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 28
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/rdss_div.sv -----
// ----------------------------------------------------------------------------
// rdss_div
// radix-2 restoring signed divider, one quotient bit a cycle, saturated result
// ----------------------------------------------------------------------------
module rdss_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rdss_pkg::div_req_type req,
   output rdss_pkg::div_rsp_type rsp
);

   logic                             busy_ff, busy_in;
   logic                             fin_ff, fin_in;
   logic                             done_ff;
   logic [rdss_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [rdss_pkg::DEN_W-1:0]       rem_ff;
   logic [rdss_pkg::NUM_W-1:0]       quo_ff;
   logic [rdss_pkg::DEN_W-1:0]       dmag_ff;
   logic                             neg_ff;
   logic signed [rdss_pkg::DATA_W-1:0] res_ff;
   logic [rdss_pkg::DEN_W:0]         shifted;
   logic                             fits;
   logic signed [rdss_pkg::PROD_W-1:0] qext;

   assign shifted = {rem_ff, quo_ff[rdss_pkg::NUM_W-1]};
   assign fits    = (shifted >= {1'b0, dmag_ff});
   assign qext    = neg_ff ? -$signed({{(rdss_pkg::PROD_W-rdss_pkg::NUM_W){1'b0}}, quo_ff})
                           :  $signed({{(rdss_pkg::PROD_W-rdss_pkg::NUM_W){1'b0}}, quo_ff});

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == rdss_pkg::DIV_CNT_W'(1)) begin
         busy_in = 1'b0;
         fin_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff  <= req.num[rdss_pkg::NUM_W-1] ? rdss_pkg::NUM_W'(-req.num) : req.num;
         dmag_ff <= req.den[rdss_pkg::DEN_W-1] ? rdss_pkg::DEN_W'(-req.den) : req.den;
         neg_ff  <= req.num[rdss_pkg::NUM_W-1] ^ req.den[rdss_pkg::DEN_W-1];
         rem_ff  <= '0;
         cnt_ff  <= rdss_pkg::DIV_CNT_W'(rdss_pkg::NUM_W);
      end else if (busy_ff) begin
         rem_ff <= fits ? rdss_pkg::DEN_W'(shifted - {1'b0, dmag_ff})
                        : shifted[rdss_pkg::DEN_W-1:0];
         quo_ff <= {quo_ff[rdss_pkg::NUM_W-2:0], fits};
         cnt_ff <= cnt_ff - rdss_pkg::DIV_CNT_W'(1);
      end
      if (fin_ff) begin
         res_ff <= rdss_pkg::sat32(qext);
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = res_ff;

endmodule

// ----- rtl/reaction_diffusion_stencil_step.sv -----
// ----------------------------------------------------------------------------
// reaction_diffusion_stencil_step
// explicit euler step of a 1d reaction-diffusion line, one cell a time
// ----------------------------------------------------------------------------
// channel  direction  payload
// req      in         tuser kind, tlast last cell, tdata genes/first/coef
// rsp      out        tdata next genes 3..6, tlast end of line
// csr      in         write enable, index, 31-bit data
//
// a coefficient item leaves the input ready; a cell item that yields a result
// keeps the input closed, its time set mostly by the bit-serial divider
// (48 quotient steps, two result stages) shared by the 28 ratios of a cell
// reset clears control, coefficient valid bits and the output queue
// a two-entry output queue lets results wait while the next item is taken
// ----------------------------------------------------------------------------
module reaction_diffusion_stencil_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // conc_gene0..6, first_cell, coef_index, coef_value, zero pad
   input  logic [rdss_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   // kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_gene3, next_gene4, next_gene5, next_gene6
   output logic [rdss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [rdss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rdss_pkg::REG_W-1:0]        csr_wdata
);

   localparam int DW = rdss_pkg::DATA_W;
   localparam int PW = rdss_pkg::PROD_W;

   // configuration registers
   logic [rdss_pkg::REG_W-1:0] gain_ff, step_ff, decay_ff;

   // control state
   rdss_pkg::state_type state_ff, state_in;
   logic [1:0]                 fill_ff, fill_in;
   logic [rdss_pkg::SRC_W-1:0] a_ff, a_in;
   logic [rdss_pkg::TGT_W-1:0] t_ff, t_in;
   logic hl_ff, hl_in, hr_ff, hr_in, eol_ff, eol_in, shift_ff, shift_in;

   // accepted item
   logic                      first_ff, last_ff;
   logic signed [DW-1:0]      cell_ff [rdss_pkg::GENES_IN];
   logic signed [DW-1:0]      cur_ff  [rdss_pkg::GENES_IN];
   logic signed [DW-1:0]      prev_ff [rdss_pkg::GENES_IN];

   // coefficient store, two rams with valid bits
   logic [rdss_pkg::COEF_HALF_BASE-1:0] rate_vld_ff, half_vld_ff;
   logic                      rd_rate_vld_ff, rd_half_vld_ff;
   logic                      rate_we, half_we;
   logic [rdss_pkg::COEF_AW-1:0] coef_waddr, coef_raddr;
   logic [DW-1:0]             rate_rdata, half_rdata;
   logic signed [DW-1:0]      rate_eff, half_eff;
   logic [rdss_pkg::COEF_IDX_W-1:0] in_idx;
   logic                      req_acc;

   // datapath
   logic signed [PW-1:0]      prod_ff;
   logic signed [DW-1:0]      mul_a, mul_b;
   logic signed [DW-1:0]      kd_ff, rate_ff, lap_ff, rea_ff, dif_ff;
   logic signed [rdss_pkg::SUM_W-1:0] sum_ff;
   logic [rdss_pkg::TARGETS-1:0][DW-1:0] next_ff;
   logic [rdss_pkg::GENE_W-1:0] gidx;
   logic signed [DW-1:0]      cen, ca;
   logic signed [rdss_pkg::DEN_W-1:0] den;
   logic signed [DW+1:0]      lap_raw, nx_raw;
   logic signed [DW-1:0]      dec_val;

   rdss_pkg::div_req_type     div_req;
   rdss_pkg::div_rsp_type     div_rsp;

   // output queue
   rdss_pkg::result_type      q_ff [2];
   logic                      q_wp_ff, q_rp_ff;
   logic [1:0]                q_cnt_ff;
   logic                      push, pop;

   assign req_tready = (state_ff == rdss_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= '0;
         step_ff  <= rdss_pkg::STEP_RESET;
         decay_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rdss_pkg::CSR_GAIN:  gain_ff  <= csr_wdata;
            rdss_pkg::CSR_STEP:  step_ff  <= csr_wdata;
            rdss_pkg::CSR_DECAY: decay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ coefficient store
   assign in_idx  = req_tdata[rdss_pkg::POS_IDX +: rdss_pkg::COEF_IDX_W];
   assign rate_we = req_acc && req_tuser == rdss_pkg::KIND_COEF
                    && in_idx < rdss_pkg::COEF_IDX_W'(rdss_pkg::COEF_HALF_BASE);
   assign half_we = req_acc && req_tuser == rdss_pkg::KIND_COEF
                    && in_idx >= rdss_pkg::COEF_IDX_W'(rdss_pkg::COEF_HALF_BASE)
                    && in_idx < rdss_pkg::COEF_IDX_W'(rdss_pkg::COEF_DEPTH);
   // rate entries sit at the index, half-saturation entries one table higher
   assign coef_waddr = rate_we ? in_idx[rdss_pkg::COEF_AW-1:0]
                     : rdss_pkg::COEF_AW'(in_idx - rdss_pkg::COEF_IDX_W'(rdss_pkg::COEF_HALF_BASE));
   assign coef_raddr = rdss_pkg::COEF_AW'({a_ff, t_ff});

   rdss_ram #(.WIDTH(DW), .DEPTH(rdss_pkg::COEF_HALF_BASE)) u_rate_ram (
      .clock (clock),
      .we    (rate_we),
      .waddr (coef_waddr),
      .wdata (req_tdata[rdss_pkg::POS_VAL +: DW]),
      .raddr (coef_raddr),
      .rdata (rate_rdata)
   );

   rdss_ram #(.WIDTH(DW), .DEPTH(rdss_pkg::COEF_HALF_BASE)) u_half_ram (
      .clock (clock),
      .we    (half_we),
      .waddr (coef_waddr),
      .wdata (req_tdata[rdss_pkg::POS_VAL +: DW]),
      .raddr (coef_raddr),
      .rdata (half_rdata)
   );

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_vld_ff <= '0;
         half_vld_ff <= '0;
      end else begin
         if (rate_we) rate_vld_ff[coef_waddr] <= 1'b1;
         if (half_we) half_vld_ff[coef_waddr] <= 1'b1;
      end
      rd_rate_vld_ff <= rate_vld_ff[coef_raddr];
      rd_half_vld_ff <= half_vld_ff[coef_raddr];
   end

   assign rate_eff = rd_rate_vld_ff ? $signed(rate_rdata) : '0;
   assign half_eff = rd_half_vld_ff ? $signed(half_rdata) : '0;

   // -------------------------------------------------------------- datapath
   assign gidx = rdss_pkg::GENE_W'(rdss_pkg::FIRST_TARGET) + rdss_pkg::GENE_W'(t_ff);
   assign cen  = cur_ff[gidx];
   // sources beyond the input genes read as zero
   assign ca   = (32'(a_ff) < 32'(rdss_pkg::GENES_IN)) ? cur_ff[rdss_pkg::GENE_W'(a_ff)] : '0;
   assign den  = {half_eff[DW-1], half_eff} + {ca[DW-1], ca};

   // zero-flux laplacian: a missing neighbour adds nothing
   assign lap_raw = (hl_ff ? ({{2{prev_ff[gidx][DW-1]}}, prev_ff[gidx]} - {{2{cen[DW-1]}}, cen})
                           : '0)
                  + (hr_ff ? ({{2{cell_ff[gidx][DW-1]}}, cell_ff[gidx]} - {{2{cen[DW-1]}}, cen})
                           : '0);
   assign dec_val = rdss_pkg::asr_sat(prod_ff);
   assign nx_raw  = {{2{cen[DW-1]}}, cen} + {{2{dif_ff[DW-1]}}, dif_ff}
                  - {{2{dec_val[DW-1]}}, dec_val} + {{2{rea_ff[DW-1]}}, rea_ff};

   // one shared multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         rdss_pkg::ST_KD: begin
            mul_a = $signed({1'b0, step_ff});
            mul_b = $signed({1'b0, decay_ff});
         end
         rdss_pkg::ST_DIV: begin
            mul_a = rate_ff;
            mul_b = div_rsp.quot;
         end
         rdss_pkg::ST_REA: begin
            mul_a = $signed({1'b0, step_ff});
            mul_b = rdss_pkg::sat32({{(PW-rdss_pkg::SUM_W){sum_ff[rdss_pkg::SUM_W-1]}}, sum_ff});
         end
         rdss_pkg::ST_DIF: begin
            mul_a = $signed({1'b0, gain_ff});
            mul_b = lap_ff;
         end
         rdss_pkg::ST_DEC: begin
            mul_a = kd_ff;
            mul_b = cen;
         end
         default: ;
      endcase
   end

   assign div_req.start = (state_ff == rdss_pkg::ST_DEN) && (den != '0);
   assign div_req.num   = {ca, {rdss_pkg::FRACTION_BITS{1'b0}}};
   assign div_req.den   = den;

   rdss_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (req_acc) begin
         first_ff <= req_tdata[rdss_pkg::POS_FIRST];
         last_ff  <= req_tlast;
         for (int g = 0; g < rdss_pkg::GENES_IN; g++) begin
            cell_ff[g] <= req_tdata[g*DW +: DW];
         end
      end
      case (state_ff)
         rdss_pkg::ST_DISPATCH: begin
            if (first_ff || fill_ff == rdss_pkg::FILL_EMPTY) begin
               cur_ff <= cell_ff;
            end
         end
         rdss_pkg::ST_KDSAT: begin
            kd_ff  <= rdss_pkg::asr_sat(prod_ff);
            sum_ff <= '0;
         end
         rdss_pkg::ST_DEN: rate_ff <= rate_eff;
         rdss_pkg::ST_ACC: begin
            sum_ff <= sum_ff + rdss_pkg::SUM_W'(prod_ff >>> rdss_pkg::FRACTION_BITS);
         end
         rdss_pkg::ST_REA: begin
            lap_ff <= rdss_pkg::sat32({{(PW-DW-2){lap_raw[DW+1]}}, lap_raw});
         end
         rdss_pkg::ST_DIF: rea_ff <= rdss_pkg::asr_sat(prod_ff);
         rdss_pkg::ST_DEC: dif_ff <= rdss_pkg::asr_sat(prod_ff);
         rdss_pkg::ST_SUMT: begin
            next_ff[t_ff] <= rdss_pkg::sat32({{(PW-DW-2){nx_raw[DW+1]}}, nx_raw});
            sum_ff        <= '0;
         end
         rdss_pkg::ST_SHIFT: begin
            prev_ff <= cur_ff;
            cur_ff  <= cell_ff;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdss_pkg::ST_IDLE;
         fill_ff  <= rdss_pkg::FILL_EMPTY;
         a_ff     <= '0;
         t_ff     <= '0;
         hl_ff    <= 1'b0;
         hr_ff    <= 1'b0;
         eol_ff   <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         a_ff     <= a_in;
         t_ff     <= t_in;
         hl_ff    <= hl_in;
         hr_ff    <= hr_in;
         eol_ff   <= eol_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      a_in     = a_ff;
      t_in     = t_ff;
      hl_in    = hl_ff;
      hr_in    = hr_ff;
      eol_in   = eol_ff;
      shift_in = shift_ff;
      push     = 1'b0;
      unique case (state_ff)
         rdss_pkg::ST_IDLE: begin
            if (req_acc && req_tuser == rdss_pkg::KIND_CELL) state_in = rdss_pkg::ST_DISPATCH;
         end
         rdss_pkg::ST_DISPATCH: begin
            if (first_ff || fill_ff == rdss_pkg::FILL_EMPTY) begin
               // new line; a lone cell is also its own right end
               if (last_ff) begin
                  hl_in = 1'b0; hr_in = 1'b0; eol_in = 1'b1; shift_in = 1'b0;
                  fill_in  = rdss_pkg::FILL_EMPTY;
                  state_in = rdss_pkg::ST_KD;
               end else begin
                  fill_in  = rdss_pkg::FILL_ONE;
                  state_in = rdss_pkg::ST_IDLE;
               end
            end else begin
               // held cell now has its right neighbour
               hl_in = (fill_ff == rdss_pkg::FILL_TWO);
               hr_in = 1'b1; eol_in = 1'b0; shift_in = 1'b1;
               state_in = rdss_pkg::ST_KD;
            end
         end
         rdss_pkg::ST_KD:    state_in = rdss_pkg::ST_KDSAT;
         rdss_pkg::ST_KDSAT: begin
            a_in = '0; t_in = '0;
            state_in = rdss_pkg::ST_RD;
         end
         rdss_pkg::ST_RD:    state_in = rdss_pkg::ST_DEN;
         rdss_pkg::ST_DEN: begin
            if (den != '0) begin
               state_in = rdss_pkg::ST_DIV;
            end else if (a_ff == rdss_pkg::SRC_W'(rdss_pkg::SOURCE_GENES - 1)) begin
               state_in = rdss_pkg::ST_REA;   // zero denominator drops the term
            end else begin
               a_in = a_ff + 1'b1;
               state_in = rdss_pkg::ST_RD;
            end
         end
         rdss_pkg::ST_DIV: begin
            if (div_rsp.done) state_in = rdss_pkg::ST_ACC;
         end
         rdss_pkg::ST_ACC: begin
            if (a_ff == rdss_pkg::SRC_W'(rdss_pkg::SOURCE_GENES - 1)) begin
               state_in = rdss_pkg::ST_REA;
            end else begin
               a_in = a_ff + 1'b1;
               state_in = rdss_pkg::ST_RD;
            end
         end
         rdss_pkg::ST_REA:   state_in = rdss_pkg::ST_DIF;
         rdss_pkg::ST_DIF:   state_in = rdss_pkg::ST_DEC;
         rdss_pkg::ST_DEC:   state_in = rdss_pkg::ST_SUMT;
         rdss_pkg::ST_SUMT: begin
            a_in = '0;
            if (t_ff == rdss_pkg::TGT_W'(rdss_pkg::TARGETS - 1)) begin
               state_in = rdss_pkg::ST_PUSH;
            end else begin
               t_in = t_ff + 1'b1;
               state_in = rdss_pkg::ST_RD;
            end
         end
         rdss_pkg::ST_PUSH: begin
            if (q_cnt_ff != 2'd2) begin
               push     = 1'b1;
               state_in = shift_ff ? rdss_pkg::ST_SHIFT : rdss_pkg::ST_IDLE;
            end
         end
         rdss_pkg::ST_SHIFT: begin
            shift_in = 1'b0;
            if (last_ff) begin
               // right boundary cell follows straight away
               fill_in = rdss_pkg::FILL_EMPTY;
               hl_in = 1'b1; hr_in = 1'b0; eol_in = 1'b1;
               state_in = rdss_pkg::ST_KD;
            end else begin
               fill_in  = rdss_pkg::FILL_TWO;
               state_in = rdss_pkg::ST_IDLE;
            end
         end
         default: state_in = rdss_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------- output queue
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign rsp_tdata  = q_ff[q_rp_ff].genes;
   assign rsp_tlast  = q_ff[q_rp_ff].eol;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff  <= 1'b0;
         q_rp_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (push) q_wp_ff <= ~q_wp_ff;
         if (pop)  q_rp_ff <= ~q_rp_ff;
         q_cnt_ff <= q_cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         q_ff[q_wp_ff].genes <= next_ff;
         q_ff[q_wp_ff].eol   <= eol_ff;
      end
   end

endmodule

// ----- rtl/rdss_chk.sv -----
// ----------------------------------------------------------------------------
// rdss_chk
// port-level checks of the stencil step, bound to the top level
// ----------------------------------------------------------------------------
`include "reaction_diffusion_stencil_step_defines.svh"

module rdss_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [rdss_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                              req_tlast,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rdss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              csr_we,
   input logic [rdss_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [rdss_pkg::REG_W-1:0]        csr_wdata
);

   // a stalled result holds
   `RDSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // reset empties the queue and opens the input
   `RDSS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid && req_tready, "not idle after reset")

   // a coefficient item leaves the block ready
   `RDSS_ASSERT_NEXT(a_coef_ready, clock, reset, req_tvalid && req_tready && req_tuser == rdss_pkg::KIND_COEF, req_tready, "coefficient item stalled input")

   // a cell item closes the input for its processing
   `RDSS_ASSERT_NEXT(a_cell_busy, clock, reset, req_tvalid && req_tready && req_tuser == rdss_pkg::KIND_CELL, !req_tready, "cell item not taken in")

endmodule

bind reaction_diffusion_stencil_step rdss_chk u_rdss_chk (.*);
